[rtl/salu_pkg.sv]
package salu_pkg;

  localparam int unsigned Width = 64;
  localparam int unsigned CntW  = 6;
  localparam logic [CntW-1:0] CntLast = CntW'(Width - 1);

  typedef enum logic [2:0] {
    OP_NEG = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_MUL,
    ST_ABS_A,
    ST_ABS_B,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [Width-1:0] x;
    logic [Width-1:0] y;
    logic             sub;
  } add_req_t;

  typedef struct packed {
    logic [Width-1:0] value;
    logic             dz;
  } res_t;

endpackage

[rtl/salu_if.sv]
interface salu_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface salu_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic               divide_by_zero;

  modport source (output valid, result_value, divide_by_zero, input ready);
  modport sink (input valid, result_value, divide_by_zero, output ready);
endinterface

[rtl/salu_adder.sv]
module salu_adder
  import salu_pkg::*;
(
  input  add_req_t         req_i,
  output logic [Width-1:0] sum_o,
  output logic             carry_o
);

  logic [Width:0] full;

  // x + y, or x - y as x + ~y + 1; carry out means x >= y unsigned on subtract
  assign full = {1'b0, req_i.x} + {1'b0, req_i.y ^ {Width{req_i.sub}}}
              + {{Width{1'b0}}, req_i.sub};

  assign sum_o   = full[Width-1:0];
  assign carry_o = full[Width];

endmodule

[rtl/salu_seq.sv]
module salu_seq
  import salu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  op_e              op_i,
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic             idle_o,
  output logic             done_o,
  input  logic             take_i,
  output res_t             res_o,
  output add_req_t         add_req_o,
  input  logic [Width-1:0] sum_i,
  input  logic             carry_i
);

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [Width-1:0] acc_q, acc_d;
  logic [Width-1:0] mq_q, mq_d;
  logic [Width-1:0] md_q, md_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             neg_q, neg_d;
  res_t             res_q, res_d;
  logic [Width-1:0] rem;

  assign rem = {acc_q[Width-2:0], mq_q[Width-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    mq_q  <= mq_d;
    md_q  <= md_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    acc_d     = acc_q;
    mq_d      = mq_q;
    md_d      = md_q;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    res_d     = res_q;
    add_req_o = '{x: acc_q, y: md_q, sub: 1'b0};
    done_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d     = op_i;
          acc_d    = a_i;
          mq_d     = a_i;
          md_d     = b_i;
          cnt_d    = '0;
          neg_d    = a_i[Width-1] ^ b_i[Width-1];
          res_d.dz = 1'b0;
          unique case (op_i)
            OP_NEG, OP_ADD, OP_SUB: state_d = ST_ONE;
            OP_MUL: begin
              acc_d   = '0;
              state_d = ST_MUL;
            end
            OP_DIV: begin
              if (b_i == '0) begin
                res_d   = '{value: '0, dz: 1'b1};
                state_d = ST_DONE;
              end else begin
                state_d = ST_ABS_A;
              end
            end
            default: begin
              res_d.value = '0;
              state_d     = ST_DONE;
            end
          endcase
        end
      end
      ST_ONE: begin
        add_req_o.x   = (op_q == OP_NEG) ? '0 : acc_q;
        add_req_o.y   = (op_q == OP_NEG) ? acc_q : md_q;
        add_req_o.sub = (op_q != OP_ADD);
        res_d.value   = sum_i;
        state_d       = ST_DONE;
      end
      ST_MUL: begin
        // shift-add, low word only
        add_req_o.y = mq_q[0] ? md_q : '0;
        acc_d       = sum_i;
        md_d        = md_q << 1;
        mq_d        = mq_q >> 1;
        cnt_d       = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          res_d.value = sum_i;
          state_d     = ST_DONE;
        end
      end
      ST_ABS_A: begin
        add_req_o = '{x: '0, y: mq_q, sub: 1'b1};
        if (mq_q[Width-1]) begin
          mq_d = sum_i;
        end
        acc_d   = '0;
        state_d = ST_ABS_B;
      end
      ST_ABS_B: begin
        add_req_o = '{x: '0, y: md_q, sub: 1'b1};
        if (md_q[Width-1]) begin
          md_d = sum_i;
        end
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: quotient bits shift into mq from the bottom
        add_req_o = '{x: rem, y: md_q, sub: 1'b1};
        acc_d     = carry_i ? sum_i : rem;
        mq_d      = {mq_q[Width-2:0], carry_i};
        cnt_d     = cnt_q + CntW'(1);
        if (cnt_q == CntLast) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        add_req_o   = '{x: '0, y: mq_q, sub: 1'b1};
        res_d.value = neg_q ? sum_i : mq_q;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        done_o = 1'b1;
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);
  assign res_o  = res_q;

endmodule

[rtl/signed_64bit_alu_unit.sv]
// Signed 64-bit ALU: negate, add, subtract, multiply (low word), divide.
// Input channel in_i carries operation, operand_a, operand_b; output channel
// out_o carries result_value and divide_by_zero. One result beat per input
// beat, in order.
// in_i.ready is high only while the sequencer is idle; one beat is worked at
// a time through a single shared 64-bit adder.
// Work per input beat before its result reaches out_o:
//   negate, add, subtract: a single pass through the adder
//   multiply: 64 shift-add passes through the adder
//   divide: two magnitude passes, 64 restoring steps, sign fix
//   divide by zero, unused operation codes: no adder pass
// The next input beat is taken once the result has moved into the output
// register, so a held output does not block it; a second result waits in
// the sequencer until out_o.ready frees the output register.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// out_o.valid; no result in flight survives it.
module signed_64bit_alu_unit
  import salu_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  salu_in_if.sink       in_i,
  salu_out_if.source    out_o
);

  add_req_t         add_req;
  logic [Width-1:0] sum;
  logic             carry;
  logic             idle;
  logic             done;
  logic             load;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  salu_adder u_adder (
    .req_i   (add_req),
    .sum_o   (sum),
    .carry_o (carry)
  );

  salu_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_i.valid),
    .op_i      (op_e'(in_i.operation)),
    .a_i       (in_i.operand_a),
    .b_i       (in_i.operand_b),
    .idle_o    (idle),
    .done_o    (done),
    .take_i    (load),
    .res_o     (res),
    .add_req_o (add_req),
    .sum_i     (sum),
    .carry_i   (carry)
  );

  assign in_i.ready = idle;
  assign load       = done & (~out_valid_q | out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_value   = out_q.value;
  assign out_o.divide_by_zero = out_q.dz;

endmodule
